FILE: design/fbb_pkg.sv
// ----------------------------------------------------------------------------
// Framebuffer blitter package
// Shared widths, field offsets, opcodes, command and status bundles, and the
// small helper functions used by the controller and the datapath.
// ----------------------------------------------------------------------------
package fbb_pkg;

    // Coordinate and extent widths.
    localparam int MAX_WIDTH = 4096;
    localparam int GLYPH_W   = 8;
    localparam int COORD_W   = 12;
    localparam int EXT_W     = 13;
    localparam int SUM_W     = 14;
    localparam int GX_W      = 13;
    localparam int GIDX_W    = 3;

    // Register widths.
    localparam int STRIDE_W  = 13;
    localparam int BPP_W     = 3;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
    localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP    = 1'b1;

    // Payload widths.
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 26;
    localparam int CNT_W   = 3;
    localparam int PROD_W  = 25;
    localparam int OP_W    = 2;

    // Input tdata layout, lowest bit first.
    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + COORD_W;
    localparam int EXT_X_LSB  = POS_Y_LSB + COORD_W;
    localparam int EXT_Y_LSB  = EXT_X_LSB + EXT_W;
    localparam int COLOUR_LSB = EXT_Y_LSB + EXT_W;
    localparam int GLYPH_LSB  = COLOUR_LSB + DATA_W;
    localparam int SRC_LSB    = GLYPH_LSB + GLYPH_W;
    localparam int IN_USED_W  = SRC_LSB + DATA_W;
    localparam int IN_W       = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_USED_W = ADDR_W + DATA_W + CNT_W;
    localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FILL = 2'd0,
        OP_LOAD_COPY = 2'd1,
        OP_GLYPH_ROW = 2'd2,
        OP_STEP      = 2'd3
    } fbb_op_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FILL = 2'd1,
        MODE_COPY = 2'd2
    } fbb_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic arm_fill;
        logic arm_copy;
        logic step_load;
        logic glyph_load;
        logic glyph_pick;
        logic mul;
        logic sum;
        logic emit;
    } fbb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rect_active;
        logic glyph_more;
        logic out_free;
    } fbb_stat_t;

    // Effective pixel size: zero acts as one byte, anything above four as four.
    function automatic logic [CNT_W-1:0] pixel_bytes(input logic [BPP_W-1:0] bpp);
        logic [CNT_W-1:0] n;
        case (bpp)
            3'd0:    n = 3'd1;
            3'd1:    n = 3'd1;
            3'd2:    n = 3'd2;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd4;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        case (n)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // Clamp an end coordinate to the framebuffer limit.
    function automatic logic [EXT_W-1:0] clip_end(input logic [SUM_W-1:0] v);
        logic [EXT_W-1:0] r;
        if (v > SUM_W'(MAX_WIDTH)) begin
            r = EXT_W'(MAX_WIDTH);
        end else begin
            r = v[EXT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/fbb_ctrl.sv
// ----------------------------------------------------------------------------
// Framebuffer blitter controller
// Sequences each transaction through the datapath: load, glyph bit pick,
// stride multiply, column add and result emit.
// ----------------------------------------------------------------------------
module fbb_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fbb_pkg::OP_W-1:0]      s_tuser,
    input  fbb_pkg::fbb_stat_t            stat,
    output fbb_pkg::fbb_cmd_t             cmd
);
    import fbb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PICK = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUM  = 5'b01000,
        S_EMIT = 5'b10000
    } fbb_state_t;

    fbb_state_t state_reg;
    fbb_state_t state_next;
    fbb_op_t    op;

    assign op       = fbb_op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (op)
                        OP_LOAD_FILL: cmd.arm_fill = 1'b1;
                        OP_LOAD_COPY: cmd.arm_copy = 1'b1;
                        OP_GLYPH_ROW: begin
                            cmd.glyph_load = 1'b1;
                            state_next     = S_PICK;
                        end
                        OP_STEP: begin
                            if (stat.rect_active) begin
                                cmd.step_load = 1'b1;
                                state_next    = S_MUL;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PICK: begin
                if (stat.glyph_more) begin
                    cmd.glyph_pick = 1'b1;
                    state_next     = S_MUL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.glyph_more ? S_PICK : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && !stat.out_free) |=> (state_reg == S_EMIT))
        else $error("emit state left while output register busy");
    a_step_needs_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_load |-> stat.rect_active)
        else $error("step issued with no armed rectangle");
    a_emit_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !stat.glyph_more) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after final write");
`endif

endmodule

FILE: design/fbb_datapath.sv
// ----------------------------------------------------------------------------
// Framebuffer blitter datapath
// Holds the configuration, the rectangle cursor, the glyph row, the address
// pipeline registers and the output register.
// ----------------------------------------------------------------------------
module fbb_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fbb_pkg::IN_W-1:0]        s_tdata,
    input  fbb_pkg::fbb_cmd_t               cmd,
    output fbb_pkg::fbb_stat_t              stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbb_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbb_pkg::CFG_W-1:0]       cfg_wdata
);
    import fbb_pkg::*;

    // Input fields.
    logic [COORD_W-1:0] in_pos_x;
    logic [COORD_W-1:0] in_pos_y;
    logic [EXT_W-1:0]   in_ext_x;
    logic [EXT_W-1:0]   in_ext_y;
    logic [DATA_W-1:0]  in_colour;
    logic [GLYPH_W-1:0] in_glyph;
    logic [DATA_W-1:0]  in_src;

    assign in_pos_x  = s_tdata[POS_X_LSB  +: COORD_W];
    assign in_pos_y  = s_tdata[POS_Y_LSB  +: COORD_W];
    assign in_ext_x  = s_tdata[EXT_X_LSB  +: EXT_W];
    assign in_ext_y  = s_tdata[EXT_Y_LSB  +: EXT_W];
    assign in_colour = s_tdata[COLOUR_LSB +: DATA_W];
    assign in_glyph  = s_tdata[GLYPH_LSB  +: GLYPH_W];
    assign in_src    = s_tdata[SRC_LSB    +: DATA_W];

    // Configuration.
    logic [STRIDE_W-1:0] stride_reg;
    logic [BPP_W-1:0]    bpp_reg;

    // Rectangle state.
    fbb_mode_t          mode_reg;
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;
    logic [COORD_W-1:0] left_reg;
    logic [EXT_W-1:0]   right_reg;
    logic [EXT_W-1:0]   bottom_reg;
    logic [DATA_W-1:0]  fill_colour_reg;

    // Work registers for the pixel in flight.
    logic               glyph_active_reg;
    logic [GLYPH_W-1:0] gmask_reg;
    logic [COORD_W-1:0] gbase_reg;
    logic [GX_W-1:0]    px_reg;
    logic [COORD_W-1:0] py_reg;
    logic [DATA_W-1:0]  wdata_reg;
    logic               wlast_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  lin_reg;

    // Output register.
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_last_reg;

    // Rectangle arming.
    logic [EXT_W-1:0] arm_xe;
    logic [EXT_W-1:0] arm_ye;
    logic             arm_ok;

    always_comb begin
        if (cmd.arm_copy) begin
            arm_xe = clip_end({2'b00, in_pos_x} + {1'b0, in_ext_x});
            arm_ye = clip_end({2'b00, in_pos_y} + {1'b0, in_ext_y});
        end else begin
            arm_xe = clip_end({1'b0, in_ext_x});
            arm_ye = clip_end({1'b0, in_ext_y});
        end
        arm_ok = ({1'b0, in_pos_x} < arm_xe) && ({1'b0, in_pos_y} < arm_ye);
    end

    // Cursor advance in row-major order.
    logic [EXT_W-1:0] x_inc;
    logic [EXT_W-1:0] y_inc;
    logic             x_wrap;
    logic             y_done;

    assign x_inc  = {1'b0, cur_x_reg} + EXT_W'(1);
    assign y_inc  = {1'b0, cur_y_reg} + EXT_W'(1);
    assign x_wrap = (x_inc >= right_reg);
    assign y_done = (y_inc >= bottom_reg);

    // Leftmost remaining glyph pixel: the highest set bit of the mask.
    logic [GIDX_W-1:0]  g_hi;
    logic [GIDX_W-1:0]  g_col;
    logic [GLYPH_W-1:0] g_rest;

    always_comb begin
        g_hi = '0;
        for (int i = 0; i < GLYPH_W; i++) begin
            if (gmask_reg[i]) begin
                g_hi = GIDX_W'(i);
            end
        end
        g_col  = GIDX_W'(GLYPH_W - 1) - g_hi;
        g_rest = gmask_reg & ~(GLYPH_W'(1) << g_hi);
    end

    // Byte address scaling and byte count at emit time.
    logic [CNT_W-1:0]  n_pix;
    logic [CNT_W-1:0]  n_wr;
    logic [ADDR_W-1:0] addr_scaled;

    always_comb begin
        n_pix = pixel_bytes(bpp_reg);
        n_wr  = (glyph_active_reg && n_pix > CNT_W'(3)) ? CNT_W'(3) : n_pix;
        case (n_pix)
            3'd1:    addr_scaled = lin_reg;
            3'd2:    addr_scaled = lin_reg << 1;
            3'd3:    addr_scaled = lin_reg + (lin_reg << 1);
            default: addr_scaled = lin_reg << 2;
        endcase
    end

    logic out_valid_next;
    assign out_valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg       <= STRIDE_RESET;
            bpp_reg          <= BPP_RESET;
            mode_reg         <= MODE_IDLE;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            bottom_reg       <= '0;
            fill_colour_reg  <= '0;
            glyph_active_reg <= 1'b0;
            gmask_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_STRIDE: stride_reg <= cfg_wdata[STRIDE_W-1:0];
                    REG_BPP:    bpp_reg    <= cfg_wdata[BPP_W-1:0];
                    default:    stride_reg <= stride_reg;
                endcase
            end
            if (cmd.arm_fill || cmd.arm_copy) begin
                left_reg   <= in_pos_x;
                cur_x_reg  <= in_pos_x;
                cur_y_reg  <= in_pos_y;
                right_reg  <= arm_xe;
                bottom_reg <= arm_ye;
                if (cmd.arm_fill) begin
                    fill_colour_reg <= in_colour;
                end
                if (!arm_ok) begin
                    mode_reg <= MODE_IDLE;
                end else if (cmd.arm_fill) begin
                    mode_reg <= MODE_FILL;
                end else begin
                    mode_reg <= MODE_COPY;
                end
            end
            if (cmd.step_load) begin
                glyph_active_reg <= 1'b0;
                px_reg           <= {1'b0, cur_x_reg};
                py_reg           <= cur_y_reg;
                wdata_reg        <= (mode_reg == MODE_FILL) ? fill_colour_reg : in_src;
                wlast_reg        <= x_wrap && y_done;
                if (x_wrap) begin
                    cur_x_reg <= left_reg;
                    if (y_done) begin
                        mode_reg <= MODE_IDLE;
                    end else begin
                        cur_y_reg <= y_inc[COORD_W-1:0];
                    end
                end else begin
                    cur_x_reg <= x_inc[COORD_W-1:0];
                end
            end
            if (cmd.glyph_load) begin
                glyph_active_reg <= 1'b1;
                gmask_reg        <= in_glyph;
                gbase_reg        <= in_pos_x;
                py_reg           <= in_pos_y;
                wdata_reg        <= in_colour;
            end
            if (cmd.glyph_pick) begin
                gmask_reg <= g_rest;
                px_reg    <= {1'b0, gbase_reg} + GX_W'(g_col);
                wlast_reg <= (g_rest == '0);
            end
        end
    end

    // Address pipeline and output payload need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PROD_W'(py_reg) * PROD_W'(stride_reg);
        end
        if (cmd.sum) begin
            lin_reg <= ADDR_W'({1'b0, prod_reg} + ADDR_W'(px_reg));
        end
        if (cmd.emit) begin
            out_addr_reg <= addr_scaled;
            out_data_reg <= wdata_reg & byte_mask(n_wr);
            out_cnt_reg  <= n_wr;
            out_last_reg <= wlast_reg;
        end
    end

    assign stat.rect_active = (mode_reg != MODE_IDLE);
    assign stat.glyph_more  = glyph_active_reg && (gmask_reg != '0);
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_W - OUT_USED_W){1'b0}}, out_cnt_reg, out_data_reg, out_addr_reg};

`ifndef SYNTHESIS
    a_cursor_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_IDLE) |-> (left_reg <= cur_x_reg && {1'b0, cur_x_reg} < right_reg
                                     && {1'b0, cur_y_reg} < bottom_reg))
        else $error("rectangle cursor outside its rectangle");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_cnt_reg != '0 && out_cnt_reg <= CNT_W'(4)))
        else $error("byte count out of range");
    a_unused_bytes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_data_reg & ~byte_mask(out_cnt_reg)) == '0))
        else $error("bytes above byte count are not zero");
`endif

endmodule

FILE: design/framebuffer_blitter.sv
// Sequencing: a step's write goes through the multiply, add and emit states to the output
// register, and emit holds while that register is busy. Loads finish on acceptance; a glyph row
// runs pick, multiply, add and emit per set bit and returns to idle from pick when no bit is set.
// The stride multiply, column add and address scaling stages are walked in turn for each pixel.
// Reset: synchronous, active low; clears the sequencer, the rectangle and the output valid,
// and sets the row stride to 640 pixels and the pixel size to 4 bytes.
// ----------------------------------------------------------------------------
// Framebuffer blitter
// Generates framebuffer pixel writes for rectangle fill, rectangle copy and
// glyph rows, with byte addresses computed from the row stride and pixel size.
// ----------------------------------------------------------------------------
module framebuffer_blitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input transactions.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: pos_x[11:0], pos_y[23:12], extent_x[36:24], extent_y[49:37],
    // colour[81:50], glyph_bits[89:82], source_pixel[121:90], zero fill to bit 127.
    input  logic [fbb_pkg::IN_W-1:0]        s_tdata,
    // Fields: opcode[1:0].
    input  logic [fbb_pkg::OP_W-1:0]        s_tuser,
    // Result transactions.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: write_address[25:0], write_data[57:26], byte_count[60:58],
    // zero fill to bit 63.
    output logic [fbb_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast,
    // Configuration writes.
    input  logic                            cfg_we,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbb_pkg::CFG_W-1:0]       cfg_wdata
);
    import fbb_pkg::*;

    // The controller only accepts a transaction from its idle state. Load
    // transactions arm a rectangle in the same cycle and give no write. A step
    // captures the cursor pixel and advances the cursor, then the pixel goes
    // through the multiply, add and scale stages. A glyph row picks its set
    // bits leftmost first and runs each through the same stages. The output
    // register lets the next transaction be accepted while a write waits.
    fbb_cmd_t  cmd;
    fbb_stat_t stat;

    fbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
